### src/dci_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and saturation helper for the distance constraint impulse block
package dci_pkg;

   localparam int FRAC_BITS = 16;
   localparam int Q_W       = 32;
   localparam int SAT_W     = 80;
   localparam int BIAS_W    = 17;
   localparam int REST_W    = 31;

   localparam logic [BIAS_W-1:0] BIAS_RESET = 17'd13107;
   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   localparam logic OP_ROPE = 1'b0;
   localparam logic OP_BAR  = 1'b1;

   // geometry and body terms carried alongside the square root
   typedef struct packed {
      logic                    bar;
      logic signed [Q_W-1:0]   ax;
      logic signed [Q_W-1:0]   ay;
      logic signed [Q_W-1:0]   bx;
      logic signed [Q_W-1:0]   by;
      logic signed [Q_W-1:0]   rx;
      logic signed [Q_W-1:0]   ry;
      logic signed [Q_W-1:0]   dvx;
      logic signed [Q_W-1:0]   dvy;
      logic [Q_W:0]            ims;
      logic [Q_W-1:0]          iia;
      logic [Q_W-1:0]          iib;
      logic [REST_W-1:0]       rest;
   } geo_type;

   // terms carried alongside the normal division and the mass terms
   typedef struct packed {
      logic                    bar;
      logic                    slack;
      logic                    dr_zero;
      logic                    rx_pos;
      logic                    ry_pos;
      logic signed [Q_W-1:0]   ax;
      logic signed [Q_W-1:0]   ay;
      logic signed [Q_W-1:0]   bx;
      logic signed [Q_W-1:0]   by;
      logic signed [Q_W-1:0]   dvx;
      logic signed [Q_W-1:0]   dvy;
      logic signed [Q_W-1:0]   diff;
      logic [Q_W:0]            ims;
      logic [Q_W-1:0]          iia;
      logic [Q_W-1:0]          iib;
   } div_side_type;

   // terms carried alongside the effective mass division
   typedef struct packed {
      logic                    slack;
      logic                    k_zero;
      logic signed [Q_W-1:0]   nx;
      logic signed [Q_W-1:0]   ny;
      logic signed [Q_W-1:0]   jvb;
   } em_side_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-Q_W:0] top;
      top = v[SAT_W-1:Q_W-1];
      if (top == '0 || top == '1) begin
         return v[Q_W-1:0];
      end
      return v[SAT_W-1] ? Q_MIN : Q_MAX;
   endfunction

endpackage

### src/distance_constraint_impulse.sv
`timescale 1ns / 1ps
// top level: streaming 2d distance constraint impulse pipeline
// Takes one constraint per clock while req_stall is low and returns its impulse on body A
// (body B gets the negation). The pipeline holds the 32-stage square root of the anchor gap
// length, the FRAC_BITS+1 stage divider that forms the unit normal and the 2*FRAC_BITS+1
// stage divider that forms the effective mass; every other step has one register stage.
// A stall on the result side holds the whole pipeline and shows on req_stall in the same
// cycle. The user must write the bar bias factor through the csr beat, always ready, only
// while no constraint is in flight; the block itself does not enforce this.
module distance_constraint_impulse #(
   parameter int FRAC_BITS = dci_pkg::FRAC_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic [63:0]                           req_lever_a,
   input  logic [63:0]                           req_lever_b,
   input  logic [63:0]                           req_center_gap,
   input  logic [63:0]                           req_vel_a,
   input  logic [63:0]                           req_vel_b,
   input  logic [63:0]                           req_spin_pair,
   input  logic [63:0]                           req_inv_mass_pair,
   input  logic [63:0]                           req_inv_inertia_pair,
   input  logic [dci_pkg::REST_W-1:0]            req_rest_length,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dci_pkg::Q_W-1:0]        rsp_impulse_x,
   output logic signed [dci_pkg::Q_W-1:0]        rsp_impulse_y,
   output logic                                  rsp_active,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [dci_pkg::BIAS_W-1:0]            csr_bias_factor
);

   localparam int QW     = dci_pkg::Q_W;
   localparam int SAT_W  = dci_pkg::SAT_W;
   localparam int QN_W   = FRAC_BITS + 1;
   localparam int QE_W   = 2 * FRAC_BITS + 1;
   localparam int GEO_W  = $bits(dci_pkg::geo_type);
   localparam int DSD_W  = $bits(dci_pkg::div_side_type);
   localparam int ESD_W  = $bits(dci_pkg::em_side_type);

   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   logic [dci_pkg::BIAS_W-1:0] bias_factor_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_factor_ff <= dci_pkg::BIAS_RESET;
      end else if (csr_valid && csr_ready) begin
         bias_factor_ff <= csr_bias_factor;
      end
   end

   // ---------------- stage 1: anchor gap and spin products
   logic signed [QW-1:0] ax_in, ay_in, bx_in, by_in, gx_in, gy_in, wa_in, wb_in;
   logic signed [QW+1:0] rx_sum, ry_sum;
   logic signed [2*QW-1:0] pa_in, pb_in, pc_in, pd_in;

   assign ax_in = $signed(req_lever_a[QW-1:0]);
   assign ay_in = $signed(req_lever_a[2*QW-1:QW]);
   assign bx_in = $signed(req_lever_b[QW-1:0]);
   assign by_in = $signed(req_lever_b[2*QW-1:QW]);
   assign gx_in = $signed(req_center_gap[QW-1:0]);
   assign gy_in = $signed(req_center_gap[2*QW-1:QW]);
   assign wa_in = $signed(req_spin_pair[QW-1:0]);
   assign wb_in = $signed(req_spin_pair[2*QW-1:QW]);
   assign rx_sum = (QW+2)'(gx_in) + (QW+2)'(ax_in) - (QW+2)'(bx_in);
   assign ry_sum = (QW+2)'(gy_in) + (QW+2)'(ay_in) - (QW+2)'(by_in);
   assign pa_in = wa_in * ay_in;
   assign pb_in = wb_in * by_in;
   assign pc_in = wa_in * ax_in;
   assign pd_in = wb_in * bx_in;

   logic v1_ff, bar1_ff;
   logic signed [QW-1:0] ax1_ff, ay1_ff, bx1_ff, by1_ff, rx1_ff, ry1_ff;
   logic signed [QW-1:0] vax1_ff, vay1_ff, vbx1_ff, vby1_ff;
   logic signed [2*QW-1:0] pa1_ff, pb1_ff, pc1_ff, pd1_ff;
   logic [QW:0] ims1_ff;
   logic [QW-1:0] iia1_ff, iib1_ff;
   logic [dci_pkg::REST_W-1:0] rest1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         bar1_ff  <= (req_opcode == dci_pkg::OP_BAR);
         ax1_ff   <= ax_in;
         ay1_ff   <= ay_in;
         bx1_ff   <= bx_in;
         by1_ff   <= by_in;
         rx1_ff   <= dci_pkg::sat_q(SAT_W'(rx_sum));
         ry1_ff   <= dci_pkg::sat_q(SAT_W'(ry_sum));
         vax1_ff  <= $signed(req_vel_a[QW-1:0]);
         vay1_ff  <= $signed(req_vel_a[2*QW-1:QW]);
         vbx1_ff  <= $signed(req_vel_b[QW-1:0]);
         vby1_ff  <= $signed(req_vel_b[2*QW-1:QW]);
         pa1_ff   <= pa_in;
         pb1_ff   <= pb_in;
         pc1_ff   <= pc_in;
         pd1_ff   <= pd_in;
         ims1_ff  <= (QW+1)'(req_inv_mass_pair[QW-1:0]) + (QW+1)'(req_inv_mass_pair[2*QW-1:QW]);
         iia1_ff  <= req_inv_inertia_pair[QW-1:0];
         iib1_ff  <= req_inv_inertia_pair[2*QW-1:QW];
         rest1_ff <= req_rest_length;
      end
   end

   // ---------------- stage 2: relative velocity and squared gap
   logic signed [2*QW-1:0] npa, npb, sqx_in, sqy_in;
   logic signed [QW-1:0] tax, tbx, tay, tby, sax, sbx, say, sby;
   dci_pkg::geo_type geo2_in;

   assign npa = -pa1_ff;
   assign npb = -pb1_ff;
   assign tax = dci_pkg::sat_q(SAT_W'(npa >>> FRAC_BITS));
   assign tbx = dci_pkg::sat_q(SAT_W'(npb >>> FRAC_BITS));
   assign tay = dci_pkg::sat_q(SAT_W'(pc1_ff >>> FRAC_BITS));
   assign tby = dci_pkg::sat_q(SAT_W'(pd1_ff >>> FRAC_BITS));
   assign sax = dci_pkg::sat_q(SAT_W'((QW+2)'(vax1_ff) + (QW+2)'(tax)));
   assign sbx = dci_pkg::sat_q(SAT_W'((QW+2)'(vbx1_ff) + (QW+2)'(tbx)));
   assign say = dci_pkg::sat_q(SAT_W'((QW+2)'(vay1_ff) + (QW+2)'(tay)));
   assign sby = dci_pkg::sat_q(SAT_W'((QW+2)'(vby1_ff) + (QW+2)'(tby)));
   assign sqx_in = rx1_ff * rx1_ff;
   assign sqy_in = ry1_ff * ry1_ff;

   always_comb begin
      geo2_in.bar  = bar1_ff;
      geo2_in.ax   = ax1_ff;
      geo2_in.ay   = ay1_ff;
      geo2_in.bx   = bx1_ff;
      geo2_in.by   = by1_ff;
      geo2_in.rx   = rx1_ff;
      geo2_in.ry   = ry1_ff;
      geo2_in.dvx  = dci_pkg::sat_q(SAT_W'((QW+2)'(sax) - (QW+2)'(sbx)));
      geo2_in.dvy  = dci_pkg::sat_q(SAT_W'((QW+2)'(say) - (QW+2)'(sby)));
      geo2_in.ims  = ims1_ff;
      geo2_in.iia  = iia1_ff;
      geo2_in.iib  = iib1_ff;
      geo2_in.rest = rest1_ff;
   end

   logic v2_ff;
   dci_pkg::geo_type geo2_ff;
   logic [2*QW-1:0] sqx2_ff, sqy2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         geo2_ff <= geo2_in;
         sqx2_ff <= $unsigned(sqx_in);
         sqy2_ff <= $unsigned(sqy_in);
      end
   end

   // ---------------- stage 3: length squared
   logic v3_ff;
   dci_pkg::geo_type geo3_ff;
   logic [2*QW-1:0] sum3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         geo3_ff <= geo2_ff;
         sum3_ff <= sqx2_ff + sqy2_ff;
      end
   end

   // ---------------- square root
   logic v4;
   logic [QW-1:0] dr4;
   logic [GEO_W-1:0] geo4_vec;
   dci_pkg::geo_type geo4;

   dci_sqrt_pipe #(.SIDE_W(GEO_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_val    (sum3_ff),
      .in_side   (geo3_ff),
      .out_valid (v4),
      .out_root  (dr4),
      .out_side  (geo4_vec)
   );
   assign geo4 = geo4_vec;

   // ---------------- stage 5: normal division setup
   logic signed [QW+1:0] diff_w;
   logic signed [QW:0] rxw, ryw;
   logic [QW:0] rx_mag, ry_mag;
   dci_pkg::div_side_type side5_in;

   assign diff_w = $signed({2'b00, dr4}) - $signed({3'b000, geo4.rest});
   assign rxw    = (QW+1)'(geo4.rx);
   assign ryw    = (QW+1)'(geo4.ry);
   assign rx_mag = rxw[QW] ? $unsigned(-rxw) : $unsigned(rxw);
   assign ry_mag = ryw[QW] ? $unsigned(-ryw) : $unsigned(ryw);

   always_comb begin
      side5_in.bar     = geo4.bar;
      side5_in.slack   = (geo4.bar == dci_pkg::OP_ROPE) && (dr4 < {1'b0, geo4.rest});
      side5_in.dr_zero = (dr4 == '0);
      side5_in.rx_pos  = !geo4.rx[QW-1] && (geo4.rx != '0);
      side5_in.ry_pos  = !geo4.ry[QW-1] && (geo4.ry != '0);
      side5_in.ax      = geo4.ax;
      side5_in.ay      = geo4.ay;
      side5_in.bx      = geo4.bx;
      side5_in.by      = geo4.by;
      side5_in.dvx     = geo4.dvx;
      side5_in.dvy     = geo4.dvy;
      side5_in.diff    = dci_pkg::sat_q(SAT_W'(diff_w));
      side5_in.ims     = geo4.ims;
      side5_in.iia     = geo4.iia;
      side5_in.iib     = geo4.iib;
   end

   logic v5_ff;
   logic [1:0][QW-1:0] rem5_ff;
   logic [1:0][QN_W-1:0] bits5_ff;
   logic [QW-1:0] dr5_ff;
   dci_pkg::div_side_type side5_ff;

   // |r| << F: the part above the quotient window starts the remainder
   always_ff @(posedge clock) begin
      if (en) begin
         rem5_ff[0]  <= rx_mag[QW:1];
         rem5_ff[1]  <= ry_mag[QW:1];
         bits5_ff[0] <= {rx_mag[0], {FRAC_BITS{1'b0}}};
         bits5_ff[1] <= {ry_mag[0], {FRAC_BITS{1'b0}}};
         dr5_ff      <= dr4;
         side5_ff    <= side5_in;
      end
   end

   // ---------------- normal division
   logic v6;
   logic [1:0][QN_W-1:0] q6;
   logic [DSD_W-1:0] side6_vec;
   dci_pkg::div_side_type side6;

   dci_div_pipe #(.DIV_W(QW), .QUOT_W(QN_W), .LANES(2), .SIDE_W(DSD_W)) u_div_n (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v5_ff),
      .in_rem     (rem5_ff),
      .in_bits    (bits5_ff),
      .in_divisor (dr5_ff),
      .in_side    (side5_ff),
      .out_valid  (v6),
      .out_quot   (q6),
      .out_side   (side6_vec)
   );
   assign side6 = side6_vec;

   // ---------------- stage 7: signed normal
   logic signed [QW-1:0] qx_s, qy_s, nx_in, ny_in;
   assign qx_s  = $signed(QW'(q6[0]));
   assign qy_s  = $signed(QW'(q6[1]));
   assign nx_in = side6.dr_zero ? '0 : (side6.rx_pos ? -qx_s : qx_s);
   assign ny_in = side6.dr_zero ? '0 : (side6.ry_pos ? -qy_s : qy_s);

   logic v7_ff;
   logic signed [QW-1:0] nx7_ff, ny7_ff;
   dci_pkg::div_side_type side7_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nx7_ff   <= nx_in;
         ny7_ff   <= ny_in;
         side7_ff <= side6;
      end
   end

   // ---------------- stage 8: lever cross and velocity dot products
   logic v8_ff;
   logic signed [2*QW-1:0] pan8_ff, pap8_ff, pbn8_ff, pbp8_ff, pjx8_ff, pjy8_ff;
   logic signed [QW-1:0] nx8_ff, ny8_ff;
   dci_pkg::div_side_type side8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         pan8_ff  <= side7_ff.ax * ny7_ff;
         pap8_ff  <= side7_ff.ay * nx7_ff;
         pbn8_ff  <= side7_ff.bx * ny7_ff;
         pbp8_ff  <= side7_ff.by * nx7_ff;
         pjx8_ff  <= nx7_ff * side7_ff.dvx;
         pjy8_ff  <= ny7_ff * side7_ff.dvy;
         nx8_ff   <= nx7_ff;
         ny8_ff   <= ny7_ff;
         side8_ff <= side7_ff;
      end
   end

   // ---------------- stage 9: sums and scaling
   logic signed [2*QW:0] da_w, db_w, dj_w;
   assign da_w = (2*QW+1)'(pan8_ff) - (2*QW+1)'(pap8_ff);
   assign db_w = (2*QW+1)'(pbn8_ff) - (2*QW+1)'(pbp8_ff);
   assign dj_w = (2*QW+1)'(pjx8_ff) + (2*QW+1)'(pjy8_ff);

   logic v9_ff;
   logic signed [QW-1:0] rna9_ff, rnb9_ff, jv9_ff, nx9_ff, ny9_ff;
   dci_pkg::div_side_type side9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rna9_ff  <= dci_pkg::sat_q(SAT_W'(da_w >>> FRAC_BITS));
         rnb9_ff  <= dci_pkg::sat_q(SAT_W'(db_w >>> FRAC_BITS));
         jv9_ff   <= dci_pkg::sat_q(SAT_W'(dj_w >>> FRAC_BITS));
         nx9_ff   <= nx8_ff;
         ny9_ff   <= ny8_ff;
         side9_ff <= side8_ff;
      end
   end

   // ---------------- stage 10: squared arms, bias, rope clamp
   logic signed [2*QW-1:0] pqa, pqb, pbias;
   logic signed [QW-1:0] jv_clamp;
   assign pqa   = rna9_ff * rna9_ff;
   assign pqb   = rnb9_ff * rnb9_ff;
   assign pbias = $signed({1'b0, bias_factor_ff}) * side9_ff.diff;
   // rope only pulls: a separating velocity is ignored
   assign jv_clamp = (!side9_ff.bar && !jv9_ff[QW-1] && jv9_ff != '0) ? '0 : jv9_ff;

   logic v10_ff;
   logic signed [QW-1:0] qa10_ff, qb10_ff, bias10_ff, jv10_ff, nx10_ff, ny10_ff;
   dci_pkg::div_side_type side10_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         qa10_ff   <= dci_pkg::sat_q(SAT_W'(pqa >>> FRAC_BITS));
         qb10_ff   <= dci_pkg::sat_q(SAT_W'(pqb >>> FRAC_BITS));
         bias10_ff <= side9_ff.bar ? dci_pkg::sat_q(SAT_W'(pbias >>> FRAC_BITS))
                                   : side9_ff.diff;
         jv10_ff   <= jv_clamp;
         nx10_ff   <= nx9_ff;
         ny10_ff   <= ny9_ff;
         side10_ff <= side9_ff;
      end
   end

   // ---------------- stage 11: inertia terms and velocity error
   logic v11_ff;
   logic [2*QW-1:0] ta11_ff, tb11_ff;
   logic signed [QW-1:0] jvb11_ff, nx11_ff, ny11_ff;
   dci_pkg::div_side_type side11_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ta11_ff   <= side10_ff.iia * $unsigned(qa10_ff);
         tb11_ff   <= side10_ff.iib * $unsigned(qb10_ff);
         jvb11_ff  <= dci_pkg::sat_q(SAT_W'((QW+2)'(bias10_ff) - (QW+2)'(jv10_ff)));
         nx11_ff   <= nx10_ff;
         ny11_ff   <= ny10_ff;
         side11_ff <= side10_ff;
      end
   end

   // ---------------- stage 12: kNormal
   logic [2*QW+1:0] k_w;
   logic [QW-1:0] k_in;
   dci_pkg::em_side_type eside_in;

   assign k_w = (2*QW+2)'(side11_ff.ims) + (2*QW+2)'(ta11_ff >> FRAC_BITS)
              + (2*QW+2)'(tb11_ff >> FRAC_BITS);
   assign k_in = (|k_w[2*QW+1:QW]) ? '1 : k_w[QW-1:0];

   always_comb begin
      eside_in.slack  = side11_ff.slack;
      eside_in.k_zero = (k_in == '0);
      eside_in.nx     = nx11_ff;
      eside_in.ny     = ny11_ff;
      eside_in.jvb    = jvb11_ff;
   end

   logic v12_ff;
   logic [QW-1:0] k12_ff;
   dci_pkg::em_side_type eside12_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         k12_ff     <= k_in;
         eside12_ff <= eside_in;
      end
   end

   // ---------------- effective mass division: 2^(2F) / k
   logic [0:0][QW-1:0] em_rem0;
   logic [0:0][QE_W-1:0] em_bits0;
   assign em_rem0[0]  = '0;
   assign em_bits0[0] = {1'b1, {(2*FRAC_BITS){1'b0}}};

   logic v13;
   logic [0:0][QE_W-1:0] qe13;
   logic [ESD_W-1:0] eside13_vec;
   dci_pkg::em_side_type eside13;

   dci_div_pipe #(.DIV_W(QW), .QUOT_W(QE_W), .LANES(1), .SIDE_W(ESD_W)) u_div_em (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (v12_ff),
      .in_rem     (em_rem0),
      .in_bits    (em_bits0),
      .in_divisor (k12_ff),
      .in_side    (eside12_ff),
      .out_valid  (v13),
      .out_quot   (qe13),
      .out_side   (eside13_vec)
   );
   assign eside13 = eside13_vec;

   // ---------------- stage 14: effective mass saturation
   logic [2*QW-1:0] qe_ext;
   logic signed [QW-1:0] em_in;
   assign qe_ext = (2*QW)'(qe13[0]);
   assign em_in  = eside13.k_zero ? '0
                 : (qe_ext > (2*QW)'($unsigned(dci_pkg::Q_MAX)) ? dci_pkg::Q_MAX
                                                                 : $signed(qe_ext[QW-1:0]));

   logic v14_ff;
   logic signed [QW-1:0] em14_ff;
   dci_pkg::em_side_type eside14_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         em14_ff    <= em_in;
         eside14_ff <= eside13;
      end
   end

   // ---------------- stage 15: lambda
   logic signed [2*QW-1:0] plam;
   assign plam = em14_ff * eside14_ff.jvb;

   logic v15_ff;
   logic signed [QW-1:0] lam15_ff;
   dci_pkg::em_side_type eside15_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lam15_ff   <= dci_pkg::sat_q(SAT_W'(plam >>> FRAC_BITS));
         eside15_ff <= eside14_ff;
      end
   end

   // ---------------- stage 16: impulse, output register
   logic signed [2*QW-1:0] pix, piy;
   assign pix = lam15_ff * eside15_ff.nx;
   assign piy = lam15_ff * eside15_ff.ny;

   logic rsp_valid_ff, rsp_active_ff;
   logic signed [QW-1:0] rsp_impulse_x_ff, rsp_impulse_y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_impulse_x_ff <= eside15_ff.slack ? '0 : dci_pkg::sat_q(SAT_W'(pix >>> FRAC_BITS));
         rsp_impulse_y_ff <= eside15_ff.slack ? '0 : dci_pkg::sat_q(SAT_W'(piy >>> FRAC_BITS));
         rsp_active_ff    <= !eside15_ff.slack;
      end
   end

   // valid bits of the register stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         v12_ff       <= 1'b0;
         v14_ff       <= 1'b0;
         v15_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v5_ff        <= v4;
         v7_ff        <= v6;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         v10_ff       <= v9_ff;
         v11_ff       <= v10_ff;
         v12_ff       <= v11_ff;
         v14_ff       <= v13;
         v15_ff       <= v14_ff;
         rsp_valid_ff <= v15_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_impulse_x = rsp_impulse_x_ff;
   assign rsp_impulse_y = rsp_impulse_y_ff;
   assign rsp_active    = rsp_active_ff;

endmodule

### src/dci_sqrt_pipe.sv
`timescale 1ns / 1ps
// pipelined integer square root, one root bit per stage, side data carried along
module dci_sqrt_pipe #(
   parameter int SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [2*dci_pkg::Q_W-1:0]   in_val,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [dci_pkg::Q_W-1:0]     out_root,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int STEPS = dci_pkg::Q_W;
   localparam int RW    = dci_pkg::Q_W;
   localparam int VW    = 2 * dci_pkg::Q_W;
   localparam int REM_W = RW + 1;

   logic              valid_ff [STEPS];
   logic [REM_W-1:0]  rem_ff   [STEPS];
   logic [REM_W-1:0]  rem_in   [STEPS];
   logic [RW-1:0]     root_ff  [STEPS];
   logic [RW-1:0]     root_in  [STEPS];
   logic [VW-1:0]     val_ff   [STEPS];
   logic [VW-1:0]     val_in   [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];

   always_comb begin
      logic [REM_W-1:0] src_rem;
      logic [RW-1:0]    src_root;
      logic [VW-1:0]    src_val;
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] trial;
      for (int s = 0; s < STEPS; s++) begin
         if (s == 0) begin
            src_rem  = '0;
            src_root = '0;
            src_val  = in_val;
         end else begin
            src_rem  = rem_ff[s-1];
            src_root = root_ff[s-1];
            src_val  = val_ff[s-1];
         end
         r2    = {src_rem, src_val[VW-1:VW-2]};
         trial = (REM_W+2)'({src_root, 2'b01});
         if (r2 >= trial) begin
            rem_in[s]  = REM_W'(r2 - trial);
            root_in[s] = {src_root[RW-2:0], 1'b1};
         end else begin
            rem_in[s]  = REM_W'(r2);
            root_in[s] = {src_root[RW-2:0], 1'b0};
         end
         val_in[s] = {src_val[VW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STEPS; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < STEPS; s++) begin
            if (s == 0) valid_ff[s] <= in_valid;
            else        valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < STEPS; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
            val_ff[s]  <= val_in[s];
            if (s == 0) side_ff[s] <= in_side;
            else        side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

### src/dci_div_pipe.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
module dci_div_pipe #(
   parameter int DIV_W  = 32,
   parameter int QUOT_W = 17,
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [LANES-1:0][DIV_W-1:0]        in_rem,
   input  logic [LANES-1:0][QUOT_W-1:0]       in_bits,
   input  logic [DIV_W-1:0]                   in_divisor,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic [LANES-1:0][QUOT_W-1:0]       out_quot,
   output logic [SIDE_W-1:0]                  out_side
);

   logic                          valid_ff [QUOT_W];
   logic [LANES-1:0][DIV_W-1:0]   rem_ff   [QUOT_W];
   logic [LANES-1:0][DIV_W-1:0]   rem_in   [QUOT_W];
   logic [LANES-1:0][QUOT_W-1:0]  bits_ff  [QUOT_W];
   logic [LANES-1:0][QUOT_W-1:0]  bits_in  [QUOT_W];
   logic [DIV_W-1:0]              dsr_ff   [QUOT_W];
   logic [SIDE_W-1:0]             side_ff  [QUOT_W];

   // dividend bits enter from the top of the bits word, quotient bits fill from the bottom
   always_comb begin
      logic [LANES-1:0][DIV_W-1:0]  src_rem;
      logic [LANES-1:0][QUOT_W-1:0] src_bits;
      logic [DIV_W-1:0]             src_dsr;
      logic [DIV_W:0]               r2;
      logic                         ge;
      for (int s = 0; s < QUOT_W; s++) begin
         if (s == 0) begin
            src_rem  = in_rem;
            src_bits = in_bits;
            src_dsr  = in_divisor;
         end else begin
            src_rem  = rem_ff[s-1];
            src_bits = bits_ff[s-1];
            src_dsr  = dsr_ff[s-1];
         end
         for (int l = 0; l < LANES; l++) begin
            r2 = {src_rem[l], src_bits[l][QUOT_W-1]};
            ge = (r2 >= {1'b0, src_dsr});
            rem_in[s][l]  = ge ? DIV_W'(r2 - {1'b0, src_dsr}) : DIV_W'(r2);
            bits_in[s][l] = {src_bits[l][QUOT_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < QUOT_W; s++) valid_ff[s] <= 1'b0;
      end else if (en) begin
         for (int s = 0; s < QUOT_W; s++) begin
            if (s == 0) valid_ff[s] <= in_valid;
            else        valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < QUOT_W; s++) begin
            rem_ff[s]  <= rem_in[s];
            bits_ff[s] <= bits_in[s];
            if (s == 0) begin
               dsr_ff[s]  <= in_divisor;
               side_ff[s] <= in_side;
            end else begin
               dsr_ff[s]  <= dsr_ff[s-1];
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = bits_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

### src/dci_checker.sv
`timescale 1ns / 1ps
// port-level checks for the distance constraint impulse block and their binding
module dci_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [dci_pkg::Q_W-1:0] rsp_impulse_x,
   input logic signed [dci_pkg::Q_W-1:0] rsp_impulse_y,
   input logic                           rsp_active
);

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_impulse_x)
         && $stable(rsp_impulse_y) && $stable(rsp_active))
      else $error("stalled result beat changed");

   // slack rope gives no impulse
   a_slack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_active |-> rsp_impulse_x == 0 && rsp_impulse_y == 0)
      else $error("inactive result with nonzero impulse");

   // input backs up only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held result");

endmodule

bind distance_constraint_impulse dci_checker u_dci_checker (.*);
